FILE: hdl/utf8v_pkg.sv
`timescale 1ns / 1ps

package utf8v_pkg;

  localparam int unsigned LimitWidth  = 10;
  localparam int unsigned LengthWidth = 11;
  localparam int unsigned CodeWidth   = 3;
  localparam int unsigned CpWidth     = 21;

  localparam logic [LimitWidth-1:0] LimitReset = 10'd64;

  typedef logic [CodeWidth-1:0] err_code_t;

  localparam err_code_t ErrNone  = 3'd0;
  localparam err_code_t ErrBlank = 3'd1;
  localparam err_code_t ErrLong  = 3'd2;
  localparam err_code_t ErrNul   = 3'd3;
  localparam err_code_t ErrUtf8  = 3'd4;

  localparam logic [CpWidth-1:0] CpMin2   = 21'h00080;
  localparam logic [CpWidth-1:0] CpMin3   = 21'h00800;
  localparam logic [CpWidth-1:0] CpMin4   = 21'h10000;
  localparam logic [CpWidth-1:0] CpMax    = 21'h10FFFF;
  localparam logic [CpWidth-1:0] SurroLow = 21'h0D800;
  localparam logic [CpWidth-1:0] SurroTop = 21'h0DFFF;

endpackage

FILE: hdl/utf8v_in_if.sv
`timescale 1ns / 1ps

interface utf8v_in_if import utf8v_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;
  logic       empty_name;

  modport source (output valid, output byte_value, output last_byte,
                  output empty_name, input ready);
  modport sink   (input valid, input byte_value, input last_byte,
                  input empty_name, output ready);
endinterface

FILE: hdl/utf8v_out_if.sv
`timescale 1ns / 1ps

interface utf8v_out_if import utf8v_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   name_ok;
  err_code_t              error_code;
  logic [LengthWidth-1:0] name_length;

  modport source (output valid, output name_ok, output error_code,
                  output name_length, input ready);
  modport sink   (input valid, input name_ok, input error_code,
                  input name_length, output ready);
endinterface

FILE: hdl/utf8_name_validator_top.sv
`timescale 1ns / 1ps

// UTF-8 name validator.
// Bytes of a trimmed name arrive on name_in, one word per byte, with
// last_byte marking the final byte; a zero-length name is a single word with
// empty_name set. One verdict word per name leaves on verdict: name_ok,
// error_code and the byte count (saturating at the limit plus one).
// The user must write the byte limit through cfg_we / cfg_data only while the
// block is idle; the block itself does not enforce this. Each accepted word is
// held in an input register, then the decode and count logic updates the
// per-name state and, on the last byte or an empty name, loads the verdict
// register. One word is taken per cycle unless a name-ending word must wait.
// When the receiver stalls, the verdict register holds its word; words that
// end no name keep flowing, and a name-ending word waits in the input
// register, with name_in.ready low, until the verdict register is free.
// Synchronous reset sets the limit to 64 bytes, clears all per-name state and
// empties both registers.
module utf8_name_validator_top import utf8v_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [LimitWidth-1:0] cfg_data,
  utf8v_in_if.sink              name_in,
  utf8v_out_if.source           verdict
);

  logic [LimitWidth-1:0] max_bytes;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_empty;

  // per-name state
  logic [LengthWidth-1:0] byte_count, byte_count_next;
  logic [1:0]             expected, expected_next;
  logic [CpWidth-1:0]     partial, partial_next;
  logic [1:0]             seq_class, seq_class_next;
  err_code_t              first_error, first_error_next;

  // verdict register
  logic                   out_valid;
  logic                   out_ok;
  err_code_t              out_code;
  logic [LengthWidth-1:0] out_length;

  logic                   s1_result, s1_move, s1_fire;
  logic                   res_ok;
  err_code_t              res_code;
  logic [LengthWidth-1:0] res_length;
  logic [CpWidth-1:0]     cp_shift;
  logic [CpWidth-1:0]     cp_min;
  err_code_t              err_final;

  assign s1_result = s1_valid && (s1_last || s1_empty);
  assign s1_move   = !(s1_result && out_valid && !verdict.ready);
  assign s1_fire   = s1_valid && s1_move;
  assign name_in.ready = !s1_valid || s1_move;

  assign cp_shift = {partial[CpWidth-7:0], s1_byte[5:0]};

  always_comb begin
    case (seq_class)
      2'd1:    cp_min = CpMin2;
      2'd2:    cp_min = CpMin3;
      default: cp_min = CpMin4;
    endcase
  end

  always_comb begin
    byte_count_next  = byte_count;
    expected_next    = expected;
    partial_next     = partial;
    seq_class_next   = seq_class;
    first_error_next = first_error;
    err_final        = ErrNone;
    res_ok           = 1'b0;
    res_code         = ErrBlank;
    res_length       = '0;

    if (s1_empty) begin
      byte_count_next  = '0;
      expected_next    = '0;
      partial_next     = '0;
      seq_class_next   = '0;
      first_error_next = ErrNone;
    end else begin
      if (byte_count <= {1'b0, max_bytes}) begin
        byte_count_next = byte_count + 1'b1;
      end

      // Once an error is recorded the remaining bytes are only counted.
      if (first_error == ErrNone) begin
        if (expected != 2'd0) begin
          if (s1_byte[7:6] != 2'b10) begin
            first_error_next = ErrUtf8;
          end else begin
            partial_next  = cp_shift;
            expected_next = expected - 2'd1;
            if (expected == 2'd1) begin
              if (cp_shift < cp_min || cp_shift > CpMax ||
                  (cp_shift >= SurroLow && cp_shift <= SurroTop)) begin
                first_error_next = ErrUtf8;
              end
            end
          end
        end else if (s1_byte == 8'h00) begin
          first_error_next = ErrNul;
        end else if (s1_byte[7] == 1'b0) begin
          first_error_next = ErrNone;
        end else if (s1_byte[7:5] == 3'b110) begin
          expected_next  = 2'd1;
          seq_class_next = 2'd1;
          partial_next   = {{(CpWidth-5){1'b0}}, s1_byte[4:0]};
        end else if (s1_byte[7:4] == 4'b1110) begin
          expected_next  = 2'd2;
          seq_class_next = 2'd2;
          partial_next   = {{(CpWidth-4){1'b0}}, s1_byte[3:0]};
        end else if (s1_byte[7:3] == 5'b11110) begin
          expected_next  = 2'd3;
          seq_class_next = 2'd3;
          partial_next   = {{(CpWidth-3){1'b0}}, s1_byte[2:0]};
        end else begin
          first_error_next = ErrUtf8;
        end
      end

      if (s1_last) begin
        // A name that stops inside a sequence is malformed.
        if (first_error_next == ErrNone && expected_next != 2'd0) begin
          err_final = ErrUtf8;
        end else begin
          err_final = first_error_next;
        end
        if (byte_count_next > {1'b0, max_bytes}) begin
          res_code = ErrLong;
        end else begin
          res_code = err_final;
        end
        res_ok     = (res_code == ErrNone);
        res_length = byte_count_next;

        byte_count_next  = '0;
        expected_next    = '0;
        partial_next     = '0;
        seq_class_next   = '0;
        first_error_next = ErrNone;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= LimitReset;
    end else if (cfg_we) begin
      max_bytes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (name_in.ready) begin
      s1_valid <= name_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (name_in.ready && name_in.valid) begin
      s1_byte  <= name_in.byte_value;
      s1_last  <= name_in.last_byte;
      s1_empty <= name_in.empty_name;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      expected    <= '0;
      partial     <= '0;
      seq_class   <= '0;
      first_error <= ErrNone;
    end else if (s1_fire) begin
      byte_count  <= byte_count_next;
      expected    <= expected_next;
      partial     <= partial_next;
      seq_class   <= seq_class_next;
      first_error <= first_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_result) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_result) begin
      out_ok     <= res_ok;
      out_code   <= res_code;
      out_length <= res_length;
    end
  end

  assign verdict.valid       = out_valid;
  assign verdict.name_ok     = out_ok;
  assign verdict.error_code  = out_code;
  assign verdict.name_length = out_length;

endmodule
